[src/llc_pkg.sv]
package llc_pkg;

  localparam int unsigned CacheEntries = 8;
  localparam int unsigned TickBits     = 16;
  localparam int unsigned LineBits     = 16;

  localparam int unsigned CountBits  = 16;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned SlotBits   = 3;
  localparam int unsigned OutLineBits = 16;

  typedef enum logic [StatusBits-1:0] {
    STATUS_REJECT = 2'd0,
    STATUS_HIT    = 2'd1,
    STATUS_FILL   = 2'd2,
    STATUS_MISS   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_e;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

endpackage

[src/llc_ram.sv]
module llc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [WIDTH-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/llc_scan.sv]
module llc_scan #(
  parameter int unsigned CACHE_ENTRIES = llc_pkg::CacheEntries,
  parameter int unsigned TICK_BITS     = llc_pkg::TickBits,
  parameter int unsigned LINE_BITS     = llc_pkg::LineBits,
  localparam int unsigned IdxBits = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  llc_pkg::scan_ctrl_t  ctrl_i,
  input  logic [IdxBits-1:0]   idx_i,
  input  logic                 entry_valid_i,
  input  logic [LINE_BITS-1:0] entry_line_i,
  input  logic [TICK_BITS-1:0] entry_stamp_i,
  input  logic [LINE_BITS-1:0] req_line_i,
  output logic                 hit_o,
  output logic [IdxBits-1:0]   hit_idx_o,
  output logic                 empty_o,
  output logic [IdxBits-1:0]   empty_idx_o,
  output logic [IdxBits-1:0]   min_idx_o,
  output logic [LINE_BITS-1:0] min_line_o
);

  logic                 hit_q, hit_d;
  logic                 empty_q, empty_d;
  logic [IdxBits-1:0]   hit_idx_q, hit_idx_d;
  logic [IdxBits-1:0]   empty_idx_q, empty_idx_d;
  logic [IdxBits-1:0]   min_idx_q, min_idx_d;
  logic [LINE_BITS-1:0] min_line_q, min_line_d;
  logic [TICK_BITS-1:0] min_stamp_q, min_stamp_d;

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    empty_d     = empty_q;
    empty_idx_d = empty_idx_q;
    min_idx_d   = min_idx_q;
    min_line_d  = min_line_q;
    min_stamp_d = min_stamp_q;
    if (ctrl_i.clear) begin
      hit_d   = 1'b0;
      empty_d = 1'b0;
    end else if (ctrl_i.sample) begin
      if (entry_valid_i && (entry_line_i == req_line_i)) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_i;
      end
      if (!entry_valid_i && !empty_q) begin
        empty_d     = 1'b1;
        empty_idx_d = idx_i;
      end
      // Strict less-than keeps the lowest index on a tie. The minimum only
      // matters when every entry is valid.
      if ((idx_i == '0) || (entry_stamp_i < min_stamp_q)) begin
        min_idx_d   = idx_i;
        min_line_d  = entry_line_i;
        min_stamp_d = entry_stamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      hit_q   <= hit_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    min_idx_q   <= min_idx_d;
    min_line_q  <= min_line_d;
    min_stamp_q <= min_stamp_d;
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign empty_o     = empty_q;
  assign empty_idx_o = empty_idx_q;
  assign min_idx_o   = min_idx_q;
  assign min_line_o  = min_line_q;

endmodule

[src/line_layout_lru_cache_policy_top.sv]
// Fully associative LRU directory of CACHE_ENTRIES entries keyed by line number. Line
// and timestamp of each entry live in a directory memory with one read port that is
// read one entry per cycle. A request that passes the line limit check is scanned over
// every entry before its result is presented; a rejected request skips the scan and goes
// straight to the finishing step. A new request is accepted once the previous one has
// left the sequencer, even while its result is still waiting on the output; only the
// finishing step waits for the output. Valid bits and per-entry stamp-cleared flags are
// flip-flops set up by reset, so no clearing pass over the memory is needed after reset.
module line_layout_lru_cache_policy_top #(
  parameter int unsigned CACHE_ENTRIES = llc_pkg::CacheEntries,
  parameter int unsigned TICK_BITS     = llc_pkg::TickBits,
  parameter int unsigned LINE_BITS     = llc_pkg::LineBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [llc_pkg::CountBits-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [15:0]                       line_number_i,
  input  logic                              fill_ok_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [llc_pkg::StatusBits-1:0]    status_o,
  output logic [llc_pkg::SlotBits-1:0]      slot_o,
  output logic                              evicted_o,
  output logic [llc_pkg::OutLineBits-1:0]   evicted_line_o
);

  localparam int unsigned IdxBits  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CntBits  = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned EntryW   = LINE_BITS + TICK_BITS;
  localparam int unsigned CmpBits  = (LINE_BITS > llc_pkg::CountBits) ? LINE_BITS
                                                                      : llc_pkg::CountBits;
  localparam logic [CntBits-1:0] LastCnt = CntBits'(CACHE_ENTRIES);

  llc_pkg::fsm_e state_q, state_d;

  logic [llc_pkg::CountBits-1:0] line_limit_q;
  logic [LINE_BITS-1:0]          req_line_q, req_line_d;
  logic                          fill_q, fill_d;
  logic                          rej_q, rej_d;
  logic [CntBits-1:0]            cnt_q, cnt_d;
  logic                          proc_vld_q, proc_vld_d;
  logic [IdxBits-1:0]            proc_idx_q, proc_idx_d;
  logic [CACHE_ENTRIES-1:0]      valid_q, valid_d;
  logic [CACHE_ENTRIES-1:0]      stale_q, stale_d;
  logic [TICK_BITS-1:0]          tick_q, tick_d;

  logic                          out_valid_q, out_valid_d;
  llc_pkg::status_e              status_q, status_d;
  logic [llc_pkg::SlotBits-1:0]  slot_q, slot_d;
  logic                          evicted_q, evicted_d;
  logic [llc_pkg::OutLineBits-1:0] evicted_line_q, evicted_line_d;

  logic [LINE_BITS-1:0] in_line;
  logic                 in_rej;
  logic                 rd_en;
  logic [IdxBits-1:0]   rd_addr;
  logic [EntryW-1:0]    rd_data;
  logic                 wr_en;
  logic [IdxBits-1:0]   wr_addr;
  logic [EntryW-1:0]    wr_data;
  logic [TICK_BITS-1:0] rd_stamp;
  logic [TICK_BITS-1:0] new_tick;
  logic                 tick_wrap;
  logic                 finish_go;
  logic                 do_update;
  logic [IdxBits-1:0]   target;

  llc_pkg::scan_ctrl_t  scan_ctrl;
  logic                 scan_hit;
  logic [IdxBits-1:0]   scan_hit_idx;
  logic                 scan_empty;
  logic [IdxBits-1:0]   scan_empty_idx;
  logic [IdxBits-1:0]   scan_min_idx;
  logic [LINE_BITS-1:0] scan_min_line;

  assign in_line = LINE_BITS'(line_number_i);
  assign in_rej  = CmpBits'(in_line) >= CmpBits'(line_limit_q);

  // An entry whose stamps were wiped by a tick wrap reads as stamp zero.
  assign rd_stamp = stale_q[proc_idx_q] ? '0 : rd_data[TICK_BITS-1:0];

  assign tick_wrap = (tick_q == '1);
  assign new_tick  = (tick_wrap ? '0 : tick_q) + TICK_BITS'(1);
  assign finish_go = !out_valid_q || out_ready_i;
  assign do_update = !rej_q && (scan_hit || fill_q);
  assign target    = scan_hit ? scan_hit_idx : (scan_empty ? scan_empty_idx : scan_min_idx);

  always_comb begin
    state_d        = state_q;
    req_line_d     = req_line_q;
    fill_d         = fill_q;
    rej_d          = rej_q;
    cnt_d          = cnt_q;
    proc_vld_d     = 1'b0;
    proc_idx_d     = proc_idx_q;
    valid_d        = valid_q;
    stale_d        = stale_q;
    tick_d         = tick_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    status_d       = status_q;
    slot_d         = slot_q;
    evicted_d      = evicted_q;
    evicted_line_d = evicted_line_q;
    in_ready_o     = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = cnt_q[IdxBits-1:0];
    wr_en          = 1'b0;
    wr_addr        = target;
    wr_data        = {req_line_q, new_tick};
    scan_ctrl      = '0;

    unique case (state_q)
      llc_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_line_d      = in_line;
          fill_d          = fill_ok_i;
          rej_d           = in_rej;
          cnt_d           = '0;
          scan_ctrl.clear = 1'b1;
          state_d         = in_rej ? llc_pkg::FSM_FINISH : llc_pkg::FSM_SCAN;
        end
      end
      llc_pkg::FSM_SCAN: begin
        // Read entry cnt while the entry read in the previous cycle is examined.
        scan_ctrl.sample = proc_vld_q;
        if (cnt_q == LastCnt) begin
          state_d = llc_pkg::FSM_FINISH;
        end else begin
          rd_en      = 1'b1;
          proc_vld_d = 1'b1;
          proc_idx_d = cnt_q[IdxBits-1:0];
          cnt_d      = cnt_q + CntBits'(1);
        end
      end
      llc_pkg::FSM_FINISH: begin
        // The write lands before the next request's scan starts, so reads
        // never meet a pending write to the same entry.
        if (finish_go) begin
          out_valid_d    = 1'b1;
          slot_d         = '0;
          evicted_d      = 1'b0;
          evicted_line_d = '0;
          priority if (rej_q) begin
            status_d = llc_pkg::STATUS_REJECT;
          end else if (scan_hit) begin
            status_d = llc_pkg::STATUS_HIT;
            slot_d   = llc_pkg::SlotBits'(target);
          end else if (fill_q) begin
            status_d = llc_pkg::STATUS_FILL;
            slot_d   = llc_pkg::SlotBits'(target);
            if (!scan_empty) begin
              evicted_d      = 1'b1;
              evicted_line_d = llc_pkg::OutLineBits'(scan_min_line);
            end
          end else begin
            status_d = llc_pkg::STATUS_MISS;
          end
          if (do_update) begin
            wr_en           = 1'b1;
            tick_d          = new_tick;
            if (tick_wrap) begin
              stale_d = '1;
            end
            stale_d[target] = 1'b0;
            valid_d[target] = 1'b1;
          end
          state_d = llc_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_d = llc_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= llc_pkg::FSM_IDLE;
      line_limit_q <= '0;
      rej_q        <= 1'b0;
      cnt_q        <= '0;
      proc_vld_q   <= 1'b0;
      valid_q      <= '0;
      stale_q      <= '1;
      tick_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        line_limit_q <= cfg_wdata_i;
      end
      rej_q       <= rej_d;
      cnt_q       <= cnt_d;
      proc_vld_q  <= proc_vld_d;
      valid_q     <= valid_d;
      stale_q     <= stale_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_line_q     <= req_line_d;
    fill_q         <= fill_d;
    proc_idx_q     <= proc_idx_d;
    status_q       <= status_d;
    slot_q         <= slot_d;
    evicted_q      <= evicted_d;
    evicted_line_q <= evicted_line_d;
  end

  llc_ram #(
    .WIDTH (EntryW),
    .DEPTH (CACHE_ENTRIES)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  llc_scan #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .TICK_BITS     (TICK_BITS),
    .LINE_BITS     (LINE_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .idx_i         (proc_idx_q),
    .entry_valid_i (valid_q[proc_idx_q]),
    .entry_line_i  (rd_data[EntryW-1:TICK_BITS]),
    .entry_stamp_i (rd_stamp),
    .req_line_i    (req_line_q),
    .hit_o         (scan_hit),
    .hit_idx_o     (scan_hit_idx),
    .empty_o       (scan_empty),
    .empty_idx_o   (scan_empty_idx),
    .min_idx_o     (scan_min_idx),
    .min_line_o    (scan_min_line)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;
  assign evicted_o      = evicted_q;
  assign evicted_line_o = evicted_line_q;

`ifndef SYNTHESIS
  a_write_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == llc_pkg::FSM_FINISH) && !rej_q)
    else $error("directory written outside the finishing step");

  a_hit_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llc_pkg::FSM_FINISH && scan_hit) |-> valid_q[scan_hit_idx])
    else $error("hit reported on an invalid entry");

  a_tick_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && tick_wrap) |=> (tick_q == TICK_BITS'(1)) && (stale_q != '0))
    else $error("tick wrap did not restart the stamps");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastCnt)
    else $error("scan counter beyond the entry count");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> valid_q[$past(wr_addr)])
    else $error("written entry not marked valid");
`endif

endmodule

[test/tb.sv]
module tb;

  localparam int unsigned CycleLimit = 5_000_000;

  typedef struct packed {
    llc_pkg::status_e                status;
    logic [llc_pkg::SlotBits-1:0]    slot;
    logic                            evicted;
    logic [llc_pkg::OutLineBits-1:0] evicted_line;
  } result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [15:0]     value;
    logic            fill;
    logic            typed;
    result_t         want;
  } row_t;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  logic [llc_pkg::CountBits-1:0]   cfg_wdata_i    = '0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic [15:0]                     line_number_i  = '0;
  logic                            fill_ok_i      = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic [llc_pkg::StatusBits-1:0]  status_o;
  logic [llc_pkg::SlotBits-1:0]    slot_o;
  logic                            evicted_o;
  logic [llc_pkg::OutLineBits-1:0] evicted_line_o;

  line_layout_lru_cache_policy_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .line_number_i (line_number_i),
    .fill_ok_i     (fill_ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .evicted_o     (evicted_o),
    .evicted_line_o(evicted_line_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the directory.
  logic                          dir_valid [llc_pkg::CacheEntries];
  logic [llc_pkg::LineBits-1:0]  dir_line  [llc_pkg::CacheEntries];
  logic [llc_pkg::TickBits-1:0]  dir_stamp [llc_pkg::CacheEntries];
  logic [llc_pkg::TickBits-1:0]  lru_tick;
  logic [llc_pkg::CountBits-1:0] lines_allowed;

  result_t     pending [$];
  row_t        directed_plan [$];
  int          mismatch_count = 0;
  int          wrap_count     = 0;
  int          n_requests     = 0;
  int          n_settings     = 0;
  int          n_evictions    = 0;
  int          n_by_status [4];
  int unsigned cycle_count    = 0;
  bit          in_gaps_on     = 1'b1;
  bit          out_stalls_on  = 1'b1;
  int          stall_left     = 0;
  logic [15:0] ws_base;
  int          ws_size;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [llc_pkg::TickBits-1:0] next_stamp();
    if (lru_tick == '1) begin
      lru_tick = '0;
      for (int i = 0; i < llc_pkg::CacheEntries; i++) dir_stamp[i] = '0;
      wrap_count++;
    end
    lru_tick = lru_tick + llc_pkg::TickBits'(1);
    return lru_tick;
  endfunction

  // Applies one request to the shadow directory and returns the result it should give.
  function automatic result_t lookup_line(logic [llc_pkg::LineBits-1:0] line, logic fill);
    result_t r;
    int      victim;
    bit      found_empty;
    r = '0;
    r.status = llc_pkg::STATUS_REJECT;
    victim = 0;
    found_empty = 1'b0;
    if (line >= lines_allowed) return r;
    for (int i = 0; i < llc_pkg::CacheEntries; i++) begin
      if (dir_valid[i] && dir_line[i] == line) begin
        dir_stamp[i] = next_stamp();
        r.status = llc_pkg::STATUS_HIT;
        r.slot = llc_pkg::SlotBits'(i);
        return r;
      end
    end
    if (!fill) begin
      r.status = llc_pkg::STATUS_MISS;
      return r;
    end
    // The first empty entry wins; otherwise the oldest stamp, lowest index on a tie.
    for (int i = 0; i < llc_pkg::CacheEntries; i++) begin
      if (!found_empty) begin
        if (!dir_valid[i]) begin
          victim = i;
          found_empty = 1'b1;
        end else if (dir_stamp[i] < dir_stamp[victim]) begin
          victim = i;
        end
      end
    end
    if (!found_empty) begin
      r.evicted = 1'b1;
      r.evicted_line = llc_pkg::OutLineBits'(dir_line[victim]);
    end
    dir_valid[victim] = 1'b1;
    dir_line[victim] = line;
    dir_stamp[victim] = next_stamp();
    r.status = llc_pkg::STATUS_FILL;
    r.slot = llc_pkg::SlotBits'(victim);
    return r;
  endfunction

  function automatic void add_row(row_kind_e kind, logic [15:0] value, logic fill,
                                  logic typed, llc_pkg::status_e st, int slot);
    row_t row;
    row = '0;
    row.kind = kind;
    row.value = value;
    row.fill = fill;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = llc_pkg::SlotBits'(slot);
    directed_plan.push_back(row);
  endfunction

  task automatic push_request(logic [llc_pkg::LineBits-1:0] line, logic fill, logic typed,
                              result_t want);
    int      gap;
    result_t predicted;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    line_number_i <= line;
    fill_ok_i <= fill;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = lookup_line(line, fill);
    if (typed) predicted = want;
    pending.push_back(predicted);
    n_requests++;
    n_by_status[predicted.status]++;
    if (predicted.evicted) n_evictions++;
  endtask

  // The register may only change once every outstanding transaction has completed.
  task automatic set_line_count(logic [llc_pkg::CountBits-1:0] value);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    lines_allowed = value;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void pick_working_set(int size);
    if (lines_allowed == '0) begin
      ws_base = '0;
      ws_size = 1;
    end else begin
      ws_size = (size > 0) ? size : $urandom_range(14, 4);
      if (ws_size > int'(lines_allowed)) ws_size = int'(lines_allowed);
      ws_base = 16'($urandom_range(int'(lines_allowed) - ws_size));
    end
  endfunction

  task automatic random_request(int ws_pct, int fill_pct);
    int          r;
    logic [15:0] line;
    r = $urandom_range(99);
    if (r < ws_pct) begin
      line = ws_base + 16'($urandom_range(ws_size - 1));
    end else if (r < ws_pct + (100 - ws_pct) / 2) begin
      line = 16'($urandom);
    end else begin
      line = 16'($urandom_range(16'hFFFF, lines_allowed));
    end
    push_request(line, $urandom_range(99) < fill_pct, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    if (!out_stalls_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(99) < 30) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    result_t wanted;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: status %0d slot %0d evicted %0b line %h",
                   status_o, slot_o, evicted_o, evicted_line_o);
        end
      end else begin
        wanted = pending.pop_front();
        if (status_o !== wanted.status || slot_o !== wanted.slot ||
            evicted_o !== wanted.evicted || evicted_line_o !== wanted.evicted_line) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d slot %0d evicted %0b line %h,",
                     wanted.status, wanted.slot, wanted.evicted, wanted.evicted_line);
            $display("          got status %0d slot %0d evicted %0b line %h",
                     status_o, slot_o, evicted_o, evicted_line_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[line_layout_lru_cache_policy_top] ERROR");
      $finish;
    end
  end

  initial begin
    int          n;
    logic [15:0] count;
    for (int i = 0; i < llc_pkg::CacheEntries; i++) begin
      dir_valid[i] = 1'b0;
      dir_line[i] = '0;
      dir_stamp[i] = '0;
    end
    for (int i = 0; i < 4; i++) n_by_status[i] = 0;
    lru_tick = '0;
    lines_allowed = '0;

    //       kind     value     fill  typed  expected                slot
    add_row(ROW_REQ, 16'h0000, 1'b1, 1'b1, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hFFFF, 1'b1, 1'b1, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_CFG, 16'hFFFF, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hFFFF, 1'b1, 1'b1, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hFFFE, 1'b0, 1'b1, llc_pkg::STATUS_MISS,   0);
    add_row(ROW_REQ, 16'hFFFE, 1'b1, 1'b1, llc_pkg::STATUS_FILL,   0);
    add_row(ROW_REQ, 16'hFFFE, 1'b0, 1'b1, llc_pkg::STATUS_HIT,    0);
    add_row(ROW_REQ, 16'h0000, 1'b1, 1'b1, llc_pkg::STATUS_FILL,   1);
    add_row(ROW_REQ, 16'h5555, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hAAAA, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hAAAA, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h0001, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h8000, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h7FFF, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h00FF, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'hFFFE, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h1234, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h4321, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h0000, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_CFG, 16'h0001, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h0000, 1'b1, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h0001, 1'b1, 1'b1, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_CFG, 16'h0000, 1'b0, 1'b0, llc_pkg::STATUS_REJECT, 0);
    add_row(ROW_REQ, 16'h0000, 1'b0, 1'b1, llc_pkg::STATUS_REJECT, 0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        set_line_count(directed_plan[i].value);
      end else begin
        push_request(directed_plan[i].value, directed_plan[i].fill,
                     directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random phases, each under its own line count, with the idling pattern redrawn every 60 requests.
    for (int p = 0; p < 8; p++) begin
      unique case (p)
        0:       count = 16'hFFFF;
        1:       count = 16'd12;
        2:       count = 16'd1;
        3:       count = 16'($urandom);
        4:       count = 16'd9;
        5:       count = 16'd0;
        6:       count = 16'($urandom_range(30, 3));
        default: count = 16'hFFFF;
      endcase
      set_line_count(count);
      n = (p == 5) ? 40 : 250;
      for (int k = 0; k < n; k++) begin
        if (k % 60 == 0) begin
          pick_working_set(0);
          in_gaps_on = ($urandom_range(3) != 0);
          out_stalls_on = ($urandom_range(3) != 0);
        end
        random_request(80, 85);
      end
    end

    // A short burst of back-to-back traffic over a small working set.
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    set_line_count(16'hFFFF);
    pick_working_set(10);
    for (int k = 0; k < 40; k++) begin
      random_request(98, 97);
    end

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (llc_pkg::CacheEntries + 4) @(posedge clk_i);

    if (pending.size() != 0) mismatch_count += pending.size();
    $display("Ran %0d requests under %0d line counts: %0d hits, %0d fills (%0d evicting),",
             n_requests, n_settings, n_by_status[llc_pkg::STATUS_HIT],
             n_by_status[llc_pkg::STATUS_FILL], n_evictions);
    $display("%0d misses without contents, %0d rejected; %0d timestamp wrap(s).",
             n_by_status[llc_pkg::STATUS_MISS], n_by_status[llc_pkg::STATUS_REJECT],
             wrap_count);
    $display("%0d result(s) were wrong or unexpected.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("[line_layout_lru_cache_policy_top] OK");
    end else begin
      $display("[line_layout_lru_cache_policy_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
src/llc_pkg.sv
src/llc_ram.sv
src/llc_scan.sv
src/line_layout_lru_cache_policy_top.sv
test/tb.sv
